// ===== src/rational_accumulator_reduce_top_defines.svh =====
// Assertion macros for the rational accumulator block.
// Used by the top level only; depends on nothing else.
`ifndef RATIONAL_ACCUMULATOR_REDUCE_TOP_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_REDUCE_TOP_DEFINES_SVH
`define RAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same-cycle implication: when ante holds, cons must hold too.
`define RAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== src/rar_pkg.sv =====
// Package for the rational accumulator: widths, kind codes, ALU op codes and sequencer states.
// No dependencies.
`default_nettype none
package rar_pkg;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_PRE  = 2'd2,
    KIND_POST = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_REM = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_DEN, ST_DIV_X, ST_DIV_Y, ST_MUL_XN, ST_MUL_YN, ST_SUM,
    ST_RED_CHK, ST_GCD, ST_DIV_N, ST_DIV_D, ST_RED_DONE, ST_INC, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  function automatic logic at_least_two(val_t v);
    return !v[VALUE_WIDTH-1] && (v >= val_t'(2));
  endfunction
endpackage
`default_nettype wire

// ===== src/rar_alu.sv =====
// Shared multicycle unit: shift-add multiply and restoring division or remainder, one bit per cycle.
// Depends on rar_pkg.
`default_nettype none
module rar_alu (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rar_pkg::alu_req_t  req_i,
  input  wire rar_pkg::val_t      a_i,
  input  wire rar_pkg::val_t      b_i,
  output logic                    done_o,
  output rar_pkg::val_t           res_o
);
  import rar_pkg::*;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  op_e              op_q, op_d;
  logic             neg_q, neg_d;
  val_t             acc_q, acc_d, mq_q, mq_d, b_q, b_d;
  logic             done_q, done_d;
  logic [VALUE_WIDTH:0] trial;
  val_t             ma, mb, fin;

  always_comb begin
    ma = a_i[VALUE_WIDTH-1] ? val_t'(-a_i) : a_i;
    mb = b_i[VALUE_WIDTH-1] ? val_t'(-b_i) : b_i;
    trial = {acc_q, mq_q[VALUE_WIDTH-1]} - {1'b0, b_q};
    fin = (op_q == OP_DIV) ? mq_q : acc_q;
    if (neg_q) fin = val_t'(-fin);
  end

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; op_d = op_q; neg_d = neg_q;
    acc_d = acc_q; mq_d = mq_q; b_d = b_q; done_d = 1'b0;
    if (!busy_q && req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      op_d   = req_i.op;
      acc_d  = '0;
      if (req_i.op == OP_MUL) begin
        mq_d = a_i; b_d = b_i; neg_d = 1'b0;
      end else begin
        mq_d = ma; b_d = mb;
        neg_d = (req_i.op == OP_DIV) ? (a_i[VALUE_WIDTH-1] ^ b_i[VALUE_WIDTH-1])
                                     : a_i[VALUE_WIDTH-1];
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (op_q == OP_MUL) begin
          acc_d = {acc_q[VALUE_WIDTH-2:0], 1'b0} + (mq_q[VALUE_WIDTH-1] ? b_q : '0);
          mq_d  = {mq_q[VALUE_WIDTH-2:0], 1'b0};
        end else if (!trial[VALUE_WIDTH]) begin
          acc_d = trial[VALUE_WIDTH-1:0];
          mq_d  = {mq_q[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[VALUE_WIDTH-2:0], mq_q[VALUE_WIDTH-1]};
          mq_d  = {mq_q[VALUE_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; neg_q <= neg_d; acc_q <= acc_d; mq_q <= mq_d; b_q <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = fin;
endmodule
`default_nettype wire

// ===== src/rational_accumulator_reduce_top.sv =====
// Top level of the rational accumulator: sequencer, fraction state and result register.
// Depends on rar_pkg, rar_alu and rational_accumulator_reduce_top_defines.svh.
`default_nettype none
`include "rational_accumulator_reduce_top_defines.svh"
// One item at a time. A load, or an add that meets a zero denominator, goes from
// acceptance through ST_INC to ST_OUT. Adds and reductions run through one shared
// unit that retires one bit per cycle. An increment passes ST_INC and ST_RED_CHK and,
// when the reduction applies, makes one unit pass per gcd remainder step, finishes the
// gcd and does the two final divisions; a post-increment reduces twice, once for the
// new and once for the old fraction. An add makes unit passes for its three multiplies
// and two divides, sums in ST_SUM, then reduces the same way. in_ready_o is low from
// acceptance until the result is taken.
module rational_accumulator_reduce_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic signed [31:0] num_in_i,
  input  wire logic signed [31:0] den_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] res_num_o,
  output logic signed [31:0] res_den_o,
  output logic             div_error_o
);
  import rar_pkg::*;

  state_e   st_q, st_d;
  val_t     hn_q, hn_d, hd_q, hd_d;
  val_t     n2_q, n2_d, d2_q, d2_d;
  val_t     t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  val_t     rn_q, rn_d, rd_q, rd_d;
  val_t     ga_q, ga_d, gb_q, gb_d;
  logic     err_q, err_d, post_q, post_d, pass_q, pass_d, go_q, go_d;
  kind_e    kind_q, kind_d;
  alu_req_t req;
  val_t     aa, ab, ar;
  logic     adone;

  rar_alu u_alu (
    .clk_i, .rst_ni, .req_i(req), .a_i(aa), .b_i(ab), .done_o(adone), .res_o(ar)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:     if (in_valid_i) st_d = ST_INC;
      ST_INC: begin
        priority case (kind_q)
          KIND_LOAD: st_d = ST_OUT;
          KIND_ADD:  st_d = ((hd_q == '0) || (d2_q == '0)) ? ST_OUT : ST_MUL_DEN;
          default:   st_d = ST_RED_CHK;
        endcase
      end
      ST_MUL_DEN:  if (adone) st_d = ST_DIV_X;
      ST_DIV_X:    if (adone) st_d = ST_DIV_Y;
      ST_DIV_Y:    if (adone) st_d = ST_MUL_XN;
      ST_MUL_XN:   if (adone) st_d = ST_MUL_YN;
      ST_MUL_YN:   if (adone) st_d = ST_SUM;
      ST_SUM:      st_d = ST_RED_CHK;
      ST_RED_CHK:  st_d = (at_least_two(ga_q) && at_least_two(gb_q)) ? ST_GCD : ST_RED_DONE;
      ST_GCD:      if (gb_q == '0) st_d = ST_DIV_N;
      ST_DIV_N:    if (adone) st_d = ST_DIV_D;
      ST_DIV_D:    if (adone) st_d = ST_RED_DONE;
      ST_RED_DONE: st_d = (post_q && !pass_q) ? ST_RED_CHK : ST_OUT;
      ST_OUT:      if (out_ready_i) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    hn_d = hn_q; hd_d = hd_q; n2_d = n2_q; d2_d = d2_q;
    t1_d = t1_q; t2_d = t2_q; t3_d = t3_q; rn_d = rn_q; rd_d = rd_q;
    ga_d = ga_q; gb_d = gb_q; err_d = err_q; post_d = post_q; pass_d = pass_q;
    kind_d = kind_q; go_d = 1'b0;
    req = '{start: 1'b0, op: OP_MUL};
    aa = t1_q; ab = t2_q;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) begin
        kind_d = kind_e'(kind_i);
        n2_d = val_t'(num_in_i); d2_d = val_t'(den_in_i);
        err_d = 1'b0; pass_d = 1'b0; go_d = 1'b1;
        post_d = (kind_e'(kind_i) == KIND_POST);
      end
      ST_INC: begin
        rn_d = hn_q; rd_d = hd_q; go_d = 1'b1;
        priority case (kind_q)
          KIND_LOAD: begin
            hn_d = n2_q; hd_d = d2_q; rn_d = n2_q; rd_d = d2_q;
          end
          KIND_ADD: begin
            if ((hd_q == '0) || (d2_q == '0)) err_d = 1'b1;
          end
          default: begin
            ga_d = hn_q + hd_q; gb_d = hd_q;
            t1_d = hn_q + hd_q; t2_d = hd_q;
          end
        endcase
      end
      ST_MUL_DEN: begin
        aa = hd_q; ab = d2_q; req = '{start: go_q, op: OP_MUL};
        if (adone) begin t3_d = ar; go_d = 1'b1; end
      end
      ST_DIV_X: begin
        aa = t3_q; ab = hd_q; req = '{start: go_q, op: OP_DIV};
        if (adone) begin t1_d = ar; go_d = 1'b1; end
      end
      ST_DIV_Y: begin
        aa = t3_q; ab = d2_q; req = '{start: go_q, op: OP_DIV};
        if (adone) begin t2_d = ar; go_d = 1'b1; end
      end
      ST_MUL_XN: begin
        aa = t1_q; ab = hn_q; req = '{start: go_q, op: OP_MUL};
        if (adone) begin t1_d = ar; go_d = 1'b1; end
      end
      ST_MUL_YN: begin
        aa = t2_q; ab = n2_q; req = '{start: go_q, op: OP_MUL};
        if (adone) t2_d = ar;
      end
      ST_SUM: begin
        t1_d = t1_q + t2_q; t2_d = t3_q;
        ga_d = t1_q + t2_q; gb_d = t3_q;
      end
      ST_RED_CHK: go_d = 1'b1;
      ST_GCD: begin
        aa = ga_q; ab = gb_q;
        if (gb_q == '0) go_d = 1'b1;
        else begin
          req = '{start: go_q, op: OP_REM};
          if (adone) begin ga_d = gb_q; gb_d = ar; go_d = 1'b1; end
        end
      end
      ST_DIV_N: begin
        aa = t1_q; ab = ga_q; req = '{start: go_q, op: OP_DIV};
        if (adone) begin t3_d = ar; go_d = 1'b1; end
      end
      ST_DIV_D: begin
        aa = t2_q; ab = ga_q; req = '{start: go_q, op: OP_DIV};
        if (adone) begin t1_d = t3_q; t2_d = ar; end
      end
      ST_RED_DONE: begin
        if (!pass_q) begin
          hn_d = t1_q; hd_d = t2_q;
          if (!post_q) begin rn_d = t1_q; rd_d = t2_q; end
          else begin
            pass_d = 1'b1;
            ga_d = rn_q; gb_d = rd_q; t1_d = rn_q; t2_d = rd_q;
          end
        end else begin
          rn_d = t1_q; rd_d = t2_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      hn_q <= '0;
      hd_q <= val_t'(1);
      go_q <= 1'b0;
    end else begin
      st_q <= st_d;
      hn_q <= hn_d;
      hd_q <= hd_d;
      go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n2_q <= n2_d; d2_q <= d2_d; t1_q <= t1_d; t2_q <= t2_d; t3_q <= t3_d;
    rn_q <= rn_d; rd_q <= rd_d; ga_q <= ga_d; gb_q <= gb_d;
    err_q <= err_d; post_q <= post_d; pass_q <= pass_d; kind_q <= kind_d;
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);
  assign res_num_o   = rn_q;
  assign res_den_o   = rd_q;
  assign div_error_o = err_q;

  `RAR_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "ready and valid overlap")
  `RAR_ASSERT_IMP(a_err_keeps, out_valid_o && div_error_o, res_den_o == hd_q, "error moved state")
  `RAR_ASSERT(a_out_after, (out_valid_o && out_ready_i) |=> in_ready_o, "no return to idle")
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for rational_accumulator_reduce_top: directed and random items,
// each result checked against a fraction predictor kept inside this file.
// Depends on rar_pkg and the RTL of the block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rar_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        err;
  } frac_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_LOAD;
  logic signed [31:0] num_in_i = '0;
  logic signed [31:0] den_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] res_num_o;
  logic signed [31:0] res_den_o;
  logic        div_error_o;

  logic [31:0] frac_num = 32'd0;
  logic [31:0] frac_den = 32'd1;
  frac_res_t   pending_fracs[$];
  int          fail_cnt = 0;
  int          sent_cnt = 0;
  int          checked_cnt = 0;
  int          kind_cnt[4] = '{0, 0, 0, 0};
  bit          quiet = 1'b0;
  bit          hold_out = 1'b0;

  rational_accumulator_reduce_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    if (a[31] ^ b[31]) q = -q;
    return q;
  endfunction

  function automatic bit two_or_more(logic [31:0] v);
    return !v[31] && v >= 32'd2;
  endfunction

  function automatic void reduce_frac(inout logic [31:0] n, inout logic [31:0] d);
    logic [31:0] a, b, t;
    if (!two_or_more(n) || !two_or_more(d)) return;
    a = n;
    b = d;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    n = n / a;
    d = d / a;
  endfunction

  function automatic frac_res_t next_frac(logic [1:0] k, logic [31:0] n2, logic [31:0] d2);
    frac_res_t r;
    logic [31:0] den, x, y, num, on, od;
    r = '{num: frac_num, den: frac_den, err: 1'b0};
    case (k)
      KIND_LOAD: begin
        frac_num = n2;
        frac_den = d2;
        r.num = n2;
        r.den = d2;
      end
      KIND_ADD: begin
        if (frac_den == 0 || d2 == 0) begin
          r.err = 1'b1;
        end else begin
          den = frac_den * d2;
          x = div_trunc(den, frac_den);
          y = div_trunc(den, d2);
          num = x * frac_num + y * n2;
          reduce_frac(num, den);
          frac_num = num;
          frac_den = den;
          r.num = num;
          r.den = den;
        end
      end
      default: begin
        on = frac_num;
        od = frac_den;
        frac_num = frac_num + frac_den;
        reduce_frac(frac_num, frac_den);
        if (k == KIND_PRE) begin
          r.num = frac_num;
          r.den = frac_den;
        end else begin
          reduce_frac(on, od);
          r.num = on;
          r.den = od;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_fracs.push_back(next_frac(kind_i, num_in_i, den_in_i));
      kind_cnt[kind_i]++;
    end
  end

  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_fracs.size() == 0) begin
        $error("result with no item outstanding");
        fail_cnt++;
      end else begin
        e = pending_fracs.pop_front();
        checked_cnt++;
        if (res_num_o !== e.num) begin
          $error("res_num: expected %0d, got %0d", $signed(e.num), res_num_o);
          fail_cnt++;
        end
        if (res_den_o !== e.den) begin
          $error("res_den: expected %0d, got %0d", $signed(e.den), res_den_o);
          fail_cnt++;
        end
        if (div_error_o !== e.err) begin
          $error("div_error: expected %0b, got %0b", e.err, div_error_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_out && (quiet || $urandom_range(99) >= 8);
  end

  initial begin
    forever begin
      wait (hold_out);
      repeat (400) @(posedge clk_i);
      hold_out = 1'b0;
    end
  end

  task automatic send_item(kind_e k, logic [31:0] n, logic [31:0] d);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    num_in_i <= n;
    den_in_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_fracs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0, 1: return $urandom_range(40) - 20;
      2: return $urandom_range(2000) - 1000;
      3: return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_item(KIND_POST, 32'd0, 32'd0);
    send_item(KIND_PRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(KIND_LOAD, 32'd6, 32'd4);
    send_item(KIND_ADD, 32'd3, 32'd9);
    send_item(KIND_PRE, 32'd0, 32'd0);
    send_item(KIND_POST, 32'd0, 32'd0);
    send_item(KIND_ADD, 32'd5, 32'd0);
    send_item(KIND_LOAD, 32'd3, 32'd0);
    send_item(KIND_ADD, 32'd1, 32'd2);
    send_item(KIND_PRE, 32'd0, 32'd0);
    send_item(KIND_LOAD, 32'd1, 32'd65536);
    send_item(KIND_ADD, 32'd1, 32'd65536);
    send_item(KIND_LOAD, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(KIND_ADD, 32'd7, 32'h8000_0000);
    send_item(KIND_LOAD, -32'sd4, 32'd6);
    send_item(KIND_POST, 32'd0, 32'd0);
    send_item(KIND_LOAD, 32'd8, -32'sd12);
    send_item(KIND_ADD, -32'sd3, 32'd5);
    send_item(KIND_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(KIND_PRE, 32'd0, 32'd0);
    send_item(KIND_POST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random(int count);
    kind_e k;
    for (int i = 0; i < count; i++) begin
      k = kind_e'($urandom_range(3));
      if ($urandom_range(9) == 0) k = KIND_LOAD;
      send_item(k, pick_value(), pick_value());
    end
  endtask

  task automatic test_backpressure();
    hold_out = 1'b1;
    test_random(20);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(200);
    test_backpressure();
    quiet = 1'b1;
    test_random(120);
    quiet = 1'b0;
    test_random(200);
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items (load %0d, add %0d, pre %0d, post %0d), checked %0d results.",
             sent_cnt, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], checked_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Timed out waiting for the block.");
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/rar_pkg.sv
src/rar_alu.sv
src/rational_accumulator_reduce_top.sv
tb/testbench.sv
